FILE: src/sdm_pkg.sv
// Shared constants, command codes and types of the SDM counter bank.
`default_nettype none
package sdm_pkg;

    // Array geometry
    localparam int LOCATIONS     = 1024;
    localparam int MAX_DIMENSION = 256;
    localparam int LANES         = 64;
    localparam int COUNTER_WIDTH = 8;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int LOC_W    = 10;
    localparam int CHUNK_W  = 2;
    localparam int WEIGHT_W = 7;
    localparam int BIU_W    = 9;
    localparam int IN_W     = 152;
    localparam int OUT_W    = 64;

    // Derived sizes
    localparam int CHUNKS     = MAX_DIMENSION / LANES;
    localparam int LANE_W     = $clog2(LANES);
    localparam int LANE_IDX_W = CHUNK_W + LANE_W;
    localparam int ROW_W      = LANES * COUNTER_WIDTH;
    localparam int ROWS       = LOCATIONS * CHUNKS;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int SUM_W      = ((COUNTER_WIDTH > WEIGHT_W) ? COUNTER_WIDTH : WEIGHT_W) + 2;

    // Limits as sized constants
    localparam logic [LOC_W:0] LOC_LIMIT = (LOC_W + 1)'(LOCATIONS);
    localparam logic [BIU_W-1:0] DIM_LIMIT = BIU_W'(MAX_DIMENSION);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TZERO = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // Configuration register indexes
    localparam logic REG_SATURATE    = 1'b0;
    localparam logic REG_BITS_IN_USE = 1'b1;

    // Item held in the update stage
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CHUNK_W-1:0]  chunk;
        logic [LANES-1:0]    data;
        logic [WEIGHT_W-1:0] weight;
        logic [LANES-1:0]    ties;
    } item_t;

    // Row update results
    typedef struct packed {
        logic [ROW_W-1:0] new_row;
        logic [LANES-1:0] read_bits;
    } alu_out_t;

endpackage
`default_nettype wire

FILE: src/sdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/sdm_row_alu.sv
// Per-lane counter update and sign readout for one row of counters.
`default_nettype none
module sdm_row_alu (
    input  wire sdm_pkg::item_t                      item,
    input  wire logic [sdm_pkg::ROW_W-1:0]          row,
    input  wire logic                               sat_en,
    input  wire logic [sdm_pkg::BIU_W-1:0]          bits_in_use,
    output sdm_pkg::alu_out_t                        res
);
    import sdm_pkg::*;

    logic [BIU_W-1:0] limit;

    // counters in use per location
    assign limit = (bits_in_use > DIM_LIMIT) ? DIM_LIMIT : bits_in_use;

    // lanes are independent
    always_comb
    begin
        logic [COUNTER_WIDTH-1:0] raw;
        logic [COUNTER_WIDTH-1:0] nxt;
        logic [SUM_W-1:0]         ext;
        logic [SUM_W-1:0]         stp;
        logic [SUM_W-1:0]         sum;
        logic [LANE_IDX_W-1:0]    lane_idx;
        logic                     in_use;
        logic                     ovf;
        logic                     pos;
        logic                     neg;
        logic                     bit_j;

        res = '0;
        for (int j = 0; j < LANES; j++)
        begin
            raw      = row[j*COUNTER_WIDTH +: COUNTER_WIDTH];
            bit_j    = item.data[j];
            lane_idx = {item.chunk, LANE_W'(j)};
            in_use   = ({1'b0, lane_idx} < limit);
            pos      = !raw[COUNTER_WIDTH-1] && (|raw);
            neg      = raw[COUNTER_WIDTH-1];

            // signed step with overflow check on the extended sum
            ext = {{(SUM_W-COUNTER_WIDTH){raw[COUNTER_WIDTH-1]}}, raw};
            stp = (item.cmd == CMD_ADD) ? SUM_W'(1) : SUM_W'(item.weight);
            sum = bit_j ? (ext + stp) : (ext - stp);
            ovf = !(&sum[SUM_W-1:COUNTER_WIDTH-1]) && (|sum[SUM_W-1:COUNTER_WIDTH-1]);

            nxt = raw;
            case (item.cmd)
                CMD_ADD, CMD_WADD:
                begin
                    if (!(sat_en && ovf))
                    begin
                        nxt = sum[COUNTER_WIDTH-1:0];
                    end
                end
                CMD_TZERO:
                begin
                    if (bit_j && pos)
                    begin
                        nxt = raw - COUNTER_WIDTH'(1);
                    end
                    else if (!bit_j && neg)
                    begin
                        nxt = raw + COUNTER_WIDTH'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    nxt = '0;
                end
                default:
                begin
                    nxt = raw;
                end
            endcase

            res.new_row[j*COUNTER_WIDTH +: COUNTER_WIDTH] = in_use ? nxt : raw;
            res.read_bits[j] = in_use && (pos || ((raw == '0) && item.ties[j]));
        end
    end

endmodule
`default_nettype wire

FILE: src/sdm_counter_bank.sv
// SDM counter bank top level: row memory, update stage, forwarding and output queue.
// A read word goes via the update stage and output queue to m_tvalid. Throughput: one word
// per cycle while s_tready is high; each word does one read-modify-write of a 512-bit row,
// with the last written row forwarded so back-to-back words to one row stay correct.
// Reset: asynchronous; after reset a clearing pass zeroes all 4096 rows, one per cycle,
// with s_tready low until it ends. saturate_enable resets to 1, bits_in_use to 256.
`default_nettype none
module sdm_counter_bank (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // command, location, chunk, data_bits, weight, tie_bits, zero pad
    input  wire logic [sdm_pkg::IN_W-1:0]     s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // read_bits
    output logic      [sdm_pkg::OUT_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [sdm_pkg::BIU_W-1:0]    cfg_data
);
    import sdm_pkg::*;

    // input word fields
    logic [CMD_W-1:0]    in_cmd;
    logic [LOC_W-1:0]    in_loc;
    logic [CHUNK_W-1:0]  in_chunk;
    logic [LANES-1:0]    in_data;
    logic [WEIGHT_W-1:0] in_weight;
    logic [LANES-1:0]    in_ties;

    assign in_cmd    = s_tdata[2:0];
    assign in_loc    = s_tdata[12:3];
    assign in_chunk  = s_tdata[14:13];
    assign in_data   = s_tdata[78:15];
    assign in_weight = s_tdata[85:79];
    assign in_ties   = s_tdata[149:86];

    // configuration
    logic             sat_en_reg;
    logic [BIU_W-1:0] biu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_en_reg <= 1'b1;
            biu_reg    <= DIM_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SATURATE:    sat_en_reg <= cfg_data[0];
                REG_BITS_IN_USE: biu_reg    <= cfg_data;
                default:         sat_en_reg <= sat_en_reg;
            endcase
        end
    end

    // clearing pass after reset
    logic              clr_busy_reg;
    logic [ROW_AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ROW_AW'(1);
            if (&clr_addr_reg)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // update stage and output queue control
    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [ROW_AW-1:0] s1_addr_reg;
    logic              s1_loc_ok_reg;
    logic              s1_rd;
    logic              s1_we;
    logic [1:0]        q_count_reg;
    logic              q_wr_ptr_reg;
    logic              q_rd_ptr_reg;
    logic [OUT_W-1:0]  q_data_reg [2];
    logic              push;
    logic              pop;
    logic              accept;

    assign s1_rd  = s1_valid_reg && (s1_item_reg.cmd == CMD_READ);
    assign s1_we  = s1_valid_reg && s1_loc_ok_reg && (s1_item_reg.cmd != CMD_READ);
    assign push   = s1_rd;
    assign pop    = m_tvalid && m_tready;
    assign s_tready = !clr_busy_reg &&
                      (({1'b0, q_count_reg} + {2'b00, s1_rd}) < (3'd2 + {2'b00, pop}));
    assign accept = s_tvalid && s_tready;

    // capture accepted word; unknown commands are dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (in_cmd <= CMD_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.cmd    <= in_cmd;
            s1_item_reg.chunk  <= in_chunk;
            s1_item_reg.data   <= in_data;
            s1_item_reg.weight <= in_weight;
            s1_item_reg.ties   <= in_ties;
            s1_addr_reg        <= {in_loc, in_chunk};
            s1_loc_ok_reg      <= ({1'b0, in_loc} < LOC_LIMIT);
        end
    end

    // counter row memory
    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;
    alu_out_t          alu_res;

    assign ram_we    = clr_busy_reg || s1_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_busy_reg ? '0 : alu_res.new_row;

    sdm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr ({in_loc, in_chunk}),
        .rdata (ram_rdata)
    );

    // forward the last written row over the read-during-write hazard
    logic              fwd_valid_reg;
    logic [ROW_AW-1:0] fwd_addr_reg;
    logic [ROW_W-1:0]  fwd_row_reg;
    logic [ROW_W-1:0]  cur_row;

    assign cur_row = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_row_reg : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_row_reg  <= alu_res.new_row;
        end
    end

    sdm_row_alu u_alu (
        .item        (s1_item_reg),
        .row         (cur_row),
        .sat_en      (sat_en_reg),
        .bits_in_use (biu_reg),
        .res         (alu_res)
    );

    // two-entry output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg  <= '0;
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_wr_ptr_reg <= !q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= !q_rd_ptr_reg;
            end
            if (push && !pop)
            begin
                q_count_reg <= q_count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                q_count_reg <= q_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[q_wr_ptr_reg] <= s1_loc_ok_reg ? alu_res.read_bits : '0;
        end
    end

    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tdata  = q_data_reg[q_rd_ptr_reg];

    // checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_stage_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s1_valid_reg)
        else $error("update stage busy during clearing pass");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (q_count_reg < 2'd2))
        else $error("output queue overflow");

    a_clear_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> (clr_addr_reg == '0))
        else $error("clearing pass ended early");

endmodule
`default_nettype wire

FILE: verif/sdm_counter_bank_test.sv
// Self-checking testbench for the SDM counter bank: stream driver, read monitor, bank predictor.
`timescale 1ns / 100ps
`default_nettype none
module sdm_counter_bank_test;
    import sdm_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_SETTLE   = 8;
    localparam int PHASES        = 10;
    localparam int WORDS_PER_PHASE = 45;
    localparam int CTR_MAX = (1 << (COUNTER_WIDTH - 1)) - 1;
    localparam int CTR_MIN = -(1 << (COUNTER_WIDTH - 1));

    // Command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

    // One input word, field by field
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [LOC_W-1:0]    location;
        logic [CHUNK_W-1:0]  chunk;
        logic [LANES-1:0]    data_bits;
        logic [WEIGHT_W-1:0] weight;
        logic [LANES-1:0]    tie_bits;
    } bank_word_t;

    // DUT connections
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [BIU_W-1:0]    cfg_data = '0;

    // Predictor state: counter store and register copies
    logic signed [COUNTER_WIDTH-1:0] bank_ctr [LOCATIONS*MAX_DIMENSION];
    logic                saturate_on = 1'b1;
    logic [BIU_W-1:0]    bits_used = BIU_W'(MAX_DIMENSION);

    bank_word_t          pending_words [$];
    logic [OUT_W-1:0]    expected_reads [$];
    bank_word_t          word_on_bus;

    // Bookkeeping
    int cycle_count = 0;
    int mismatch_count = 0;
    int words_accepted = 0;
    int reads_checked = 0;
    int sat_skips = 0;
    int tie_lanes = 0;
    int settings_run = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;

    logic [LOC_W-1:0] hot_locs [4] = '{10'd0, 10'd1, 10'd513, 10'd1023};

    // Register settings per random phase
    logic             phase_sat [PHASES];
    logic [BIU_W-1:0] phase_biu [PHASES];

    sdm_counter_bank dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Step one counter up or down; out-of-range steps are skipped when saturating
    function automatic void bank_step(input int idx, input bit up, input int step);
        int v;
        int n;
        v = int'(bank_ctr[idx]);
        n = up ? v + step : v - step;
        if (saturate_on && (n > CTR_MAX || n < CTR_MIN))
            sat_skips++;
        else
            bank_ctr[idx] = COUNTER_WIDTH'(n);
    endfunction

    // Apply one accepted word to the predicted store; reads queue their expected bits
    function automatic void bank_apply(input bank_word_t w);
        int lim;
        int lane;
        int idx;
        int v;
        logic [OUT_W-1:0] rb;
        lim = (int'(bits_used) < MAX_DIMENSION) ? int'(bits_used) : MAX_DIMENSION;
        rb = '0;
        if (w.command > CMD_READ)
            return;
        // location is 10 bits wide, so it is always inside the bank
        for (int j = 0; j < LANES; j++)
        begin
            lane = int'(w.chunk) * LANES + j;
            if (lane >= lim)
                continue;
            idx = int'(w.location) * MAX_DIMENSION + lane;
            v = int'(bank_ctr[idx]);
            case (w.command)
                CMD_ADD:   bank_step(idx, w.data_bits[j], 1);
                CMD_WADD:  bank_step(idx, w.data_bits[j], int'(w.weight));
                CMD_TZERO:
                begin
                    if (w.data_bits[j] && v > 0)
                        bank_ctr[idx] = COUNTER_WIDTH'(v - 1);
                    else if (!w.data_bits[j] && v < 0)
                        bank_ctr[idx] = COUNTER_WIDTH'(v + 1);
                end
                CMD_CLEAR: bank_ctr[idx] = '0;
                default:
                begin
                    if (v > 0)
                        rb[j] = 1'b1;
                    else if (v == 0)
                    begin
                        rb[j] = w.tie_bits[j];
                        tie_lanes++;
                    end
                end
            endcase
        end
        if (w.command == CMD_READ)
            expected_reads.push_back(rb);
    endfunction

    // Driver: bursts of words with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                bank_apply(word_on_bus);
                words_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_tdata <= {2'b00, word_on_bus.tie_bits, word_on_bus.weight,
                                word_on_bus.data_bits, word_on_bus.chunk,
                                word_on_bus.location, word_on_bus.command};
                    s_tvalid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: receiver stall pattern and read word check
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            stall_tick++;
            if (stall_tick % 48 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (stall_tick % 4 == 0);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
            if (m_tvalid && m_tready)
            begin
                if (expected_reads.size() == 0)
                    flag_mismatch($sformatf("unexpected read word %h", m_tdata));
                else
                begin
                    if (m_tdata !== expected_reads[0])
                        flag_mismatch($sformatf("read_bits %h, expected %h",
                                                m_tdata, expected_reads[0]));
                    void'(expected_reads.pop_front());
                    reads_checked++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads still outstanding",
                     cycle_count, expected_reads.size());
            $display("[sdm_counter_bank] ERROR");
            $finish;
        end
    end

    task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [LOC_W-1:0] loc,
                             input logic [CHUNK_W-1:0] chk, input logic [LANES-1:0] data,
                             input logic [WEIGHT_W-1:0] wt, input logic [LANES-1:0] ties);
        bank_word_t w;
        w.command = cmd;
        w.location = loc;
        w.chunk = chk;
        w.data_bits = data;
        w.weight = wt;
        w.tie_bits = ties;
        pending_words.push_back(w);
    endtask

    // Random word aimed at one row; biased toward heavy steps so counters hit the rails
    function automatic bank_word_t rand_word(input logic [LOC_W-1:0] loc,
                                             input logic [CHUNK_W-1:0] chk);
        bank_word_t w;
        int pick;
        w.location = loc;
        w.chunk = chk;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            w.command = CMD_ADD;
        else if (pick < 55)
            w.command = CMD_WADD;
        else if (pick < 70)
            w.command = CMD_TZERO;
        else if (pick < 75)
            w.command = CMD_CLEAR;
        else if (pick < 95)
            w.command = CMD_READ;
        else
            w.command = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        pick = $urandom_range(0, 99);
        if (pick < 30)
            w.data_bits = '1;
        else if (pick < 50)
            w.data_bits = '0;
        else
            w.data_bits = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 45)
            w.weight = WEIGHT_W'($urandom_range(100, 127));
        else if (pick < 55)
            w.weight = '0;
        else
            w.weight = WEIGHT_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            w.tie_bits = '0;
        else if (pick == 1)
            w.tie_bits = '1;
        else
            w.tie_bits = {$urandom, $urandom};
        return w;
    endfunction

    // Random traffic: runs of words to one row exercise the write-forwarding path
    task automatic queue_random(input int count);
        logic [LOC_W-1:0]   loc;
        logic [CHUNK_W-1:0] chk;
        int run;
        int n;
        n = 0;
        while (n < count)
        begin
            loc = ($urandom_range(0, 99) < 85) ? hot_locs[$urandom_range(0, 3)]
                                               : LOC_W'($urandom);
            chk = CHUNK_W'($urandom_range(0, CHUNKS - 1));
            run = ($urandom_range(0, 9) < 3) ? $urandom_range(2, 6) : 1;
            for (int k = 0; k < run && n < count; k++)
            begin
                pending_words.push_back(rand_word(loc, chk));
                n++;
            end
        end
    endtask

    // Wait until every word is sent and every read has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid || expected_reads.size() != 0);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BIU_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SATURATE)
            saturate_on = value[0];
        else
            bits_used = value;
        @(negedge clk);
    endtask

    // Sequence: reset, directed words, then random phases over register settings
    initial
    begin
        phase_sat = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                      1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_biu = '{9'd256, 9'd256, 9'd1, 9'd0, 9'd100,
                      9'd511, 9'd64, 9'd200, 9'd256, 9'd256};
        foreach (bank_ctr[i])
            bank_ctr[i] = '0;
        phase_biu[8] = BIU_W'($urandom_range(1, 256));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under reset register values
        push_word(CMD_READ,  10'd0,    2'd0, '0, 7'd0,   '1);
        push_word(CMD_READ,  10'd1023, 2'd3, '1, 7'd127, '0);
        push_word(CMD_ADD,   10'd5,    2'd1, 64'hFFFF_0000_FFFF_0000, 7'd0, '0);
        push_word(CMD_READ,  10'd5,    2'd1, '0, 7'd0, 64'h0123_4567_89AB_CDEF);
        push_word(CMD_WADD,  10'd5,    2'd1, '1, 7'd127, '0);
        push_word(CMD_WADD,  10'd5,    2'd1, 64'h5555_5555_5555_5555, 7'd0, '0);
        push_word(CMD_READ,  10'd5,    2'd1, '0, 7'd0, '1);
        push_word(CMD_TZERO, 10'd5,    2'd1, '1, 7'd0, '0);
        push_word(CMD_TZERO, 10'd5,    2'd1, '0, 7'd0, '0);
        push_word(CMD_READ,  10'd5,    2'd1, '0, 7'd0, '1);
        // saturation on the negative rail
        push_word(CMD_WADD,  10'd0,    2'd0, '0, 7'd127, '0);
        push_word(CMD_WADD,  10'd0,    2'd0, '0, 7'd127, '0);
        push_word(CMD_ADD,   10'd0,    2'd0, '0, 7'd0,   '0);
        push_word(CMD_READ,  10'd0,    2'd0, '0, 7'd0,   '1);
        // consecutive words to one row
        push_word(CMD_ADD,   10'd1023, 2'd3, '1, 7'd0, '0);
        push_word(CMD_WADD,  10'd1023, 2'd3, 64'h00FF_00FF_00FF_00FF, 7'd64, '0);
        push_word(CMD_TZERO, 10'd1023, 2'd3, '1, 7'd0, '0);
        push_word(CMD_READ,  10'd1023, 2'd3, '0, 7'd0, 64'hAAAA_AAAA_AAAA_AAAA);
        // ignored commands
        push_word(3'(CMD_BAD_FIRST), 10'd5, 2'd1, '1, 7'd127, '1);
        push_word(3'(CMD_BAD_FIRST + 3'd1), 10'd0, 2'd0, '1, 7'd127, '1);
        push_word(CMD_BAD_LAST,      10'd1023, 2'd3, '0, 7'd1, '1);
        // clear then read: every lane falls back to its tie bit
        push_word(CMD_CLEAR, 10'd5,    2'd1, '1, 7'd0, '0);
        push_word(CMD_READ,  10'd5,    2'd1, '0, 7'd0, 64'hF0F0_0F0F_F0F0_0F0F);
        push_word(CMD_READ,  10'd5,    2'd1, '0, 7'd0, '1);
        wait_idle();
        settings_run++;

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_SATURATE, BIU_W'(phase_sat[p]));
            write_reg(REG_BITS_IN_USE, phase_biu[p]);
            settings_run++;
            queue_random(WORDS_PER_PHASE);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("covered %0d words, %0d reads checked, %0d register settings",
                 words_accepted, reads_checked, settings_run);
        $display("%0d saturated steps skipped, %0d zero counters read through tie bits",
                 sat_skips, tie_lanes);
        if (mismatch_count == 0)
            $display("[sdm_counter_bank] OK");
        else
            $display("[sdm_counter_bank] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
